FILE: rtl/core/wrb_pkg.sv
// Shared types, constants and codes for the window reorder buffer.
// No dependencies; every other file refers to it by scoped names.
package wrb_pkg;

   localparam int REORDER_DEPTH      = 16;
   localparam int MAX_WINDOW_SAMPLES = 768;
   localparam int MAX_OUT            = 16;

   localparam int TYPE_W   = 8;
   localparam int INDEX_W  = 32;
   localparam int SIZE_W   = 10;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam int RUN_W    = $clog2(MAX_OUT + 1);

   // message kinds
   localparam logic [TYPE_W-1:0] MSG_DATA  = 8'd1;
   localparam logic [TYPE_W-1:0] MSG_UNEXP = 8'd2;
   localparam logic [TYPE_W-1:0] MSG_KILL  = 8'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_WINDOW      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_END         = 3'd1;
   localparam logic [STATUS_W-1:0] ST_END_PENDING = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_STALE       = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_FAR     = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORDERED_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAG_INDEX    = 4'd1;

   typedef struct packed {
      logic ordered_mode;
      logic tag_index;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } slot_entry_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  out_index;
      logic [HANDLE_W-1:0] out_handle;
      logic [SIZE_W-1:0]   out_size;
      logic                tag_valid;
      logic [STATUS_W-1:0] status;
      logic                last_of_run;
   } result_type;

   typedef struct packed {
      logic       push;
      result_type data;
   } rsp_push_type;

endpackage

FILE: rtl/core/wrb_if.sv
// Channel interfaces of the window reorder buffer: request, response, register write.
// Depends on wrb_pkg for field widths.
interface wrb_req_if;
   logic                          valid;
   logic                          ready;
   logic [wrb_pkg::TYPE_W-1:0]    msg_type;
   logic [wrb_pkg::INDEX_W-1:0]   window_index;
   logic [wrb_pkg::SIZE_W-1:0]    payload_size;
   logic [wrb_pkg::HANDLE_W-1:0]  payload_handle;
   modport source (output valid, msg_type, window_index, payload_size, payload_handle,
                   input ready);
   modport sink   (input valid, msg_type, window_index, payload_size, payload_handle,
                   output ready);
endinterface

interface wrb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wrb_pkg::INDEX_W-1:0]   out_index;
   logic [wrb_pkg::HANDLE_W-1:0]  out_handle;
   logic [wrb_pkg::SIZE_W-1:0]    out_size;
   logic                          tag_valid;
   logic [wrb_pkg::STATUS_W-1:0]  status;
   logic                          last_of_run;
   modport source (output valid, out_index, out_handle, out_size, tag_valid, status,
                   last_of_run, input ready);
   modport sink   (input valid, out_index, out_handle, out_size, tag_valid, status,
                   last_of_run, output ready);
endinterface

interface wrb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [wrb_pkg::CSR_IDX_W-1:0]   index;
   logic [wrb_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/window_reorder_buffer.sv
// Top level of the window reorder buffer: register file, sequencer, response stage.
// Depends on wrb_pkg, wrb_if, wrb_seq, wrb_slot_ram and wrb_rsp_stage.
//
// Takes window descriptors and, in ordered mode, parks each data window in
// slot (index mod REORDER_DEPTH), then releases the run of consecutive
// windows from the expected index, up to 16 per descriptor, flagging the last
// one; in pass-through mode each window goes straight out. A kill ends the
// stream (status 2 if windows are still held) and everything after it is
// dropped until reset. After reset the slot memory is cleared, one slot per
// cycle, through all REORDER_DEPTH slots; req_ch.ready stays low meanwhile,
// register writes are taken as ever. One descriptor is in work at a time: a
// descriptor is decoded, then, where a slot lookup is needed, checked against
// the slot read, and its result goes to the response register; a stored
// window instead releases each window of its run by a read and a clear of the
// slot memory, whose read data is registered. Descriptors of unknown type
// pass only the decode state. A held response stalls the sequencer.
module window_reorder_buffer #(
   parameter int REORDER_DEPTH = wrb_pkg::REORDER_DEPTH
) (
   input logic       clock,
   input logic       reset,
   wrb_req_if.sink   req_ch,
   wrb_rsp_if.source rsp_ch,
   wrb_csr_if.sink   csr_ch
);

   wrb_pkg::cfg_type      cfg_ff, cfg_in;
   wrb_pkg::rsp_push_type push;
   logic                  out_free;

   // register writes always complete in one transfer
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            wrb_pkg::CSR_ORDERED_MODE: cfg_in.ordered_mode = csr_ch.data[0];
            wrb_pkg::CSR_TAG_INDEX:    cfg_in.tag_index    = csr_ch.data[0];
            default:                   cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ordered_mode <= 1'b1;
         cfg_ff.tag_index    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // descriptor decode, slot read-modify-write, release runs
   wrb_seq #(.REORDER_DEPTH(REORDER_DEPTH)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_ch   (req_ch),
      .out_free (out_free),
      .out_push (push)
   );

   // response register: the next result can be formed while this one waits
   wrb_rsp_stage u_rsp (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: rtl/core/wrb_slot_ram.sv
// Slot memory: one write port, one read port, registered read data.
// Depends on wrb_pkg for the entry type.
module wrb_slot_ram #(
   parameter  int DEPTH = wrb_pkg::REORDER_DEPTH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  wrb_pkg::slot_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output wrb_pkg::slot_entry_type rd_data
);

   wrb_pkg::slot_entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/core/wrb_rsp_stage.sv
// Output register of the response channel; decouples the sequencer from the sink.
// Depends on wrb_pkg and wrb_if.
module wrb_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  wrb_pkg::rsp_push_type push,
   output logic                  free,
   wrb_rsp_if.source             rsp_ch
);

   logic                 valid_ff, valid_in;
   wrb_pkg::result_type  data_ff;

   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (push.push) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         data_ff <= push.data;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_index   = data_ff.out_index;
   assign rsp_ch.out_handle  = data_ff.out_handle;
   assign rsp_ch.out_size    = data_ff.out_size;
   assign rsp_ch.tag_valid   = data_ff.tag_valid;
   assign rsp_ch.status      = data_ff.status;
   assign rsp_ch.last_of_run = data_ff.last_of_run;

endmodule

FILE: rtl/core/wrb_seq.sv
// Sequencer: decodes descriptors, read-modify-writes the slot memory, runs releases.
// Depends on wrb_pkg, wrb_if and wrb_slot_ram.
module wrb_seq #(
   parameter int REORDER_DEPTH = wrb_pkg::REORDER_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wrb_pkg::cfg_type      cfg,
   wrb_req_if.sink               req_ch,
   input  logic                  out_free,
   output wrb_pkg::rsp_push_type out_push
);

   localparam int AW = $clog2(REORDER_DEPTH);
   localparam int CW = $clog2(REORDER_DEPTH + 1);
   localparam int IW = wrb_pkg::INDEX_W;

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_DECODE  = 3'd2;
   localparam logic [2:0] S_CHECK   = 3'd3;
   localparam logic [2:0] S_REL_RD  = 3'd4;
   localparam logic [2:0] S_REL_CHK = 3'd5;
   localparam logic [2:0] S_FLUSH   = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic [IW-1:0]               expected_ff, expected_in;
   logic [AW-1:0]               exp_slot_ff, exp_slot_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [wrb_pkg::RUN_W-1:0]   run_ff, run_in;
   logic                        ended_ff, ended_in;
   logic                        hold_valid_ff, hold_valid_in;
   wrb_pkg::result_type         hold_ff, hold_in;

   logic [wrb_pkg::TYPE_W-1:0]   type_ff;
   logic [IW-1:0]                idx_ff;
   logic [wrb_pkg::SIZE_W-1:0]   size_ff;
   logic [wrb_pkg::HANDLE_W-1:0] handle_ff;
   logic [IW-1:0]                dist_ff;
   logic                         below_ff;
   logic [AW-1:0]                slot_ff, slot_in;

   logic                         accept;
   logic [wrb_pkg::SIZE_W-1:0]   size_sat;
   logic [AW:0]                  slot_sum;
   logic [AW-1:0]                slot_calc;
   logic                         too_far;
   logic                         take;
   logic [AW-1:0]                exp_slot_next;

   logic                    wr_en, rd_en;
   logic [AW-1:0]           wr_addr, rd_addr;
   wrb_pkg::slot_entry_type wr_data, rd_data;

   wrb_slot_ram #(.DEPTH(REORDER_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   assign size_sat = (req_ch.payload_size > wrb_pkg::SIZE_W'(wrb_pkg::MAX_WINDOW_SAMPLES)) ?
                     wrb_pkg::SIZE_W'(wrb_pkg::MAX_WINDOW_SAMPLES) : req_ch.payload_size;

   // slot of the incoming index, from the expected slot and the distance (< depth)
   assign slot_sum  = {1'b0, exp_slot_ff} + {1'b0, dist_ff[AW-1:0]};
   assign slot_calc = (slot_sum >= (AW+1)'(REORDER_DEPTH)) ?
                      AW'(slot_sum - (AW+1)'(REORDER_DEPTH)) : slot_sum[AW-1:0];
   assign too_far   = (dist_ff >= IW'(REORDER_DEPTH));

   // expected slot follows expected_index mod depth, including the 2^32 wrap
   assign exp_slot_next = (expected_ff == '1) ? '0 :
                          (exp_slot_ff == AW'(REORDER_DEPTH - 1)) ? '0 : exp_slot_ff + 1'b1;

   assign take = rd_data.valid && (run_ff < wrb_pkg::RUN_W'(wrb_pkg::MAX_OUT));

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      expected_in   = expected_ff;
      exp_slot_in   = exp_slot_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      ended_in      = ended_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      slot_in       = slot_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = slot_calc;
      out_push      = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(REORDER_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && !ended_ff) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            hold_in             = '0;
            hold_in.out_index   = idx_ff;
            hold_in.last_of_run = 1'b1;
            hold_valid_in       = 1'b1;
            state_in            = S_FLUSH;
            if (type_ff == wrb_pkg::MSG_UNEXP) begin
               hold_in.status = wrb_pkg::ST_BAD_TYPE;
            end else if (type_ff == wrb_pkg::MSG_KILL) begin
               ended_in          = 1'b1;
               hold_in.out_index = expected_ff;
               hold_in.status    = (count_ff != '0) ? wrb_pkg::ST_END_PENDING : wrb_pkg::ST_END;
            end else if (type_ff == wrb_pkg::MSG_DATA) begin
               hold_in.out_handle = handle_ff;
               hold_in.out_size   = size_ff;
               if (!cfg.ordered_mode) begin
                  hold_in.tag_valid = cfg.tag_index;
                  hold_in.status    = wrb_pkg::ST_WINDOW;
               end else if (below_ff) begin
                  hold_in.status = wrb_pkg::ST_STALE;
               end else if (too_far) begin
                  hold_in.status = wrb_pkg::ST_TOO_FAR;
               end else begin
                  hold_in.status = wrb_pkg::ST_STALE;
                  rd_en          = 1'b1;
                  rd_addr        = slot_calc;
                  slot_in        = slot_calc;
                  state_in       = S_CHECK;
               end
            end else begin
               hold_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_CHECK: begin
            if (rd_data.valid) begin
               state_in = S_FLUSH;   // occupied slot: stale result already in hold
            end else begin
               wr_en          = 1'b1;
               wr_addr        = slot_ff;
               wr_data.valid  = 1'b1;
               wr_data.handle = handle_ff;
               wr_data.size   = size_ff;
               count_in       = count_ff + 1'b1;
               run_in         = '0;
               hold_valid_in  = 1'b0;
               state_in       = S_REL_RD;
            end
         end
         S_REL_RD: begin
            rd_en    = 1'b1;
            rd_addr  = exp_slot_ff;
            state_in = S_REL_CHK;
         end
         S_REL_CHK: begin
            if (take) begin
               if (!hold_valid_ff || out_free) begin
                  out_push.push             = hold_valid_ff;
                  out_push.data             = hold_ff;
                  out_push.data.last_of_run = 1'b0;
                  wr_en              = 1'b1;
                  wr_addr            = exp_slot_ff;
                  wr_data            = '0;
                  hold_in.out_index  = expected_ff;
                  hold_in.out_handle = rd_data.handle;
                  hold_in.out_size   = rd_data.size;
                  hold_in.tag_valid  = cfg.tag_index;
                  hold_in.status     = wrb_pkg::ST_WINDOW;
                  hold_in.last_of_run = 1'b1;
                  hold_valid_in      = 1'b1;
                  expected_in        = expected_ff + 1'b1;
                  exp_slot_in        = exp_slot_next;
                  count_in           = count_ff - 1'b1;
                  run_in             = run_ff + 1'b1;
                  state_in           = S_REL_RD;
               end
            end else begin
               state_in = hold_valid_ff ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_push.push             = 1'b1;
               out_push.data             = hold_ff;
               out_push.data.last_of_run = 1'b1;
               hold_valid_in             = 1'b0;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         expected_ff   <= '0;
         exp_slot_ff   <= '0;
         count_ff      <= '0;
         run_ff        <= '0;
         ended_ff      <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         expected_ff   <= expected_in;
         exp_slot_ff   <= exp_slot_in;
         count_ff      <= count_in;
         run_ff        <= run_in;
         ended_ff      <= ended_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      slot_ff <= slot_in;
      if (accept) begin
         type_ff   <= req_ch.msg_type;
         idx_ff    <= req_ch.window_index;
         size_ff   <= size_sat;
         handle_ff <= req_ch.payload_handle;
         dist_ff   <= req_ch.window_index - expected_ff;
         below_ff  <= (req_ch.window_index < expected_ff);
      end
   end

endmodule
